### rtl/shortest_path_engine_defines.svh
// Assertion macros shared by the shortest path engine RTL.
`ifndef SHORTEST_PATH_ENGINE_DEFINES_SVH
`define SHORTEST_PATH_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shortest path engine check failed");

// Next-cycle implication, checked outside reset.
`define SPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shortest path engine check failed");

`endif

### rtl/spe_pkg.sv
// Types and constants shared by the shortest path engine.
package spe_pkg;

   localparam int DIST_BITS = 20;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
   localparam int MAX_OUT = 16;

   typedef enum logic [1:0] {
      STAT_PATH     = 2'd0,
      STAT_NOROUTE  = 2'd1,
      STAT_ACCEPTED = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_RELAX_RD,
      S_RELAX_EDGE,
      S_RELAX_NODE,
      S_TDIST,
      S_TRACE_RD,
      S_TRACE_WAIT,
      S_EMIT_RD,
      S_EMIT_OUT,
      S_NOROUTE
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [3:0]  edge_from;
      logic [3:0]  edge_to;
      logic [15:0] edge_weight;
      logic [3:0]  path_start;
      logic [3:0]  path_end;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [3:0]            path_node;
      logic [DIST_BITS-1:0]  total_distance;
      logic                  last;
   } rsp_type;

endpackage

### rtl/spe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module spe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/shortest_path_engine.sv
// Top level of the shortest path engine: edge store, Dijkstra sequencer and result port.
//
// The engine keeps a directed weighted graph and answers single-pair shortest path
// queries. A transfer with mode 0 appends an edge and returns one result (accepted,
// or table full when the store is full or a node number is out of range); the engine
// stays idle, so the next item can be taken straight away, subject to the output rule
// below. A transfer with mode 1 runs Dijkstra from path_start to path_end and returns
// the path nodes from start to end, each carrying the total distance, with last set on
// the final one, or a single no-route result. Every node starts at infinite distance,
// ties in the selection go to the lowest node number and distances saturate at 2^20-1.
// The run time of a query is set by the single read port of the node memory, which is
// swept once per settled node and once more at the end, and by the edge memory, which
// is read one edge at a time. No clearing pass is needed after reset: node entries are
// only used once a query has written them. A query is taken while a finished result
// still waits in the output register; an edge is taken only once that register is
// empty or being emptied.
`include "shortest_path_engine_defines.svh"

module shortest_path_engine #(
   parameter int MAX_NODES   = 16,
   parameter int MAX_EDGES   = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spe_pkg::rsp_type rsp_payload
);

   localparam int DB = spe_pkg::DIST_BITS;
   localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC = $clog2(MAX_EDGES + 1);
   localparam int SW = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;
   localparam int EW = 2 * NB + WEIGHT_BITS;
   localparam int NW = DB + NB;

   // Sequencer state.
   spe_pkg::state_type state_ff, state_in;

   logic [EC-1:0]        edge_count_ff, edge_count_in;
   logic [MAX_NODES-1:0] reached_ff, reached_in;
   logic [MAX_NODES-1:0] settled_ff, settled_in;
   logic [NB-1:0]        start_ff, start_in;
   logic [NB-1:0]        end_ff, end_in;
   logic [3:0]           end_raw_ff, end_raw_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [NB-1:0]        pend_idx_ff, pend_idx_in;
   logic                 found_ff, found_in;
   logic [NB-1:0]        best_ff, best_in;
   logic [DB-1:0]        best_dist_ff, best_dist_in;
   logic [EC-1:0]        ei_ff, ei_in;
   logic [NB-1:0]        dst_ff, dst_in;
   logic [DB-1:0]        nd_ff, nd_in;
   logic [NB-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        len_ff, len_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [DB-1:0]        tot_ff, tot_in;
   spe_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   logic          edge_we;
   logic [EA-1:0] edge_waddr;
   logic [EW-1:0] edge_wdata;
   logic [EW-1:0] edge_rdata;
   logic          node_we;
   logic [NB-1:0] node_waddr;
   logic [NW-1:0] node_wdata;
   logic [NB-1:0] node_raddr;
   logic [NW-1:0] node_rdata;
   logic          path_we;
   logic [NB-1:0] path_waddr;
   logic [NB-1:0] path_wdata;
   logic [NB-1:0] path_raddr;
   logic [NB-1:0] path_rdata;

   // Decoded fields and helpers.
   logic                   out_free;
   logic                   req_fire;
   logic                   edge_ok;
   logic                   query_ok;
   logic [DB-1:0]          rd_dist;
   logic [NB-1:0]          rd_pred;
   logic [NB-1:0]          e_src;
   logic [NB-1:0]          e_dst;
   logic [WEIGHT_BITS-1:0] e_w;
   logic                   relax_hit;
   logic [SW-1:0]          relax_sum;
   logic [EC-1:0]          ei_next;
   logic                   edges_done;
   logic                   scan_take;
   logic                   scan_found;
   logic [NB-1:0]          scan_best;
   logic [DB-1:0]          scan_bdist;
   logic                   scan_end;
   logic                   trace_done;
   logic [CW-1:0]          len_eff;
   logic                   emit_last;
   logic                   restart_scan;

   spe_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (ei_ff[EA-1:0]),
      .rd_data (edge_rdata)
   );

   spe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   spe_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_path_ram (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (path_waddr),
      .wr_data (path_wdata),
      .rd_addr (path_raddr),
      .rd_data (path_rdata)
   );

   // The output register can take a new result when empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == spe_pkg::S_IDLE) && (req_payload.mode || out_free);
   assign req_fire  = req_valid && req_ready;

   assign edge_ok  = (edge_count_ff != EC'(MAX_EDGES))
                  && (32'(req_payload.edge_from) < MAX_NODES)
                  && (32'(req_payload.edge_to) < MAX_NODES);
   assign query_ok = (32'(req_payload.path_start) < MAX_NODES)
                  && (32'(req_payload.path_end) < MAX_NODES);

   assign rd_dist = node_rdata[NW-1:NB];
   assign rd_pred = node_rdata[NB-1:0];
   assign e_src   = edge_rdata[EW-1:NB+WEIGHT_BITS];
   assign e_dst   = edge_rdata[NB+WEIGHT_BITS-1:WEIGHT_BITS];
   assign e_w     = edge_rdata[WEIGHT_BITS-1:0];

   // An edge is relaxed only when it lies below the fill count, leaves the node just
   // settled and points at a node not yet settled.
   assign relax_hit  = (ei_ff < edge_count_ff) && (e_src == best_ff) && !settled_ff[e_dst];
   assign relax_sum  = SW'(best_dist_ff) + SW'(e_w);
   assign ei_next    = ei_ff + EC'(1);
   assign edges_done = (ei_next >= edge_count_ff);

   // Minimum search over the node distances, one entry per cycle as it returns from
   // the memory. A strict compare keeps the lowest index on a tie.
   assign scan_take  = pend_vld_ff && reached_ff[pend_idx_ff] && !settled_ff[pend_idx_ff]
                    && (!found_ff || (rd_dist < best_dist_ff));
   assign scan_found = found_ff || scan_take;
   assign scan_best  = scan_take ? pend_idx_ff : best_ff;
   assign scan_bdist = scan_take ? rd_dist : best_dist_ff;
   assign scan_end   = (cnt_ff == CW'(MAX_NODES));

   assign trace_done = (cur_ff == start_ff) || (32'(len_ff) + 32'd1 >= MAX_NODES);
   assign len_eff    = (32'(len_ff) > 32'(spe_pkg::MAX_OUT)) ? CW'(spe_pkg::MAX_OUT) : len_ff;
   assign emit_last  = (k_ff == len_eff - CW'(1));
   assign path_raddr = NB'(len_eff - CW'(1) - k_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spe_pkg::S_IDLE: begin
            if (req_fire && req_payload.mode) begin
               state_in = query_ok ? spe_pkg::S_INIT : spe_pkg::S_NOROUTE;
            end
         end
         spe_pkg::S_INIT: begin
            state_in = spe_pkg::S_SCAN;
         end
         spe_pkg::S_SCAN: begin
            if (scan_end) begin
               if (scan_found) begin
                  state_in = spe_pkg::S_RELAX_RD;
               end else if (reached_ff[end_ff]) begin
                  state_in = spe_pkg::S_TDIST;
               end else begin
                  state_in = spe_pkg::S_NOROUTE;
               end
            end
         end
         spe_pkg::S_RELAX_RD: begin
            state_in = spe_pkg::S_RELAX_EDGE;
         end
         spe_pkg::S_RELAX_EDGE: begin
            if (relax_hit) begin
               state_in = spe_pkg::S_RELAX_NODE;
            end else begin
               state_in = edges_done ? spe_pkg::S_SCAN : spe_pkg::S_RELAX_RD;
            end
         end
         spe_pkg::S_RELAX_NODE: begin
            state_in = edges_done ? spe_pkg::S_SCAN : spe_pkg::S_RELAX_RD;
         end
         spe_pkg::S_TDIST: begin
            state_in = spe_pkg::S_TRACE_RD;
         end
         spe_pkg::S_TRACE_RD: begin
            state_in = trace_done ? spe_pkg::S_EMIT_RD : spe_pkg::S_TRACE_WAIT;
         end
         spe_pkg::S_TRACE_WAIT: begin
            state_in = spe_pkg::S_TRACE_RD;
         end
         spe_pkg::S_EMIT_RD: begin
            state_in = spe_pkg::S_EMIT_OUT;
         end
         spe_pkg::S_EMIT_OUT: begin
            if (out_free) begin
               state_in = emit_last ? spe_pkg::S_IDLE : spe_pkg::S_EMIT_RD;
            end
         end
         spe_pkg::S_NOROUTE: begin
            if (out_free) begin
               state_in = spe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spe_pkg::S_IDLE;
         end
      endcase
   end

   assign restart_scan = (state_in == spe_pkg::S_SCAN) && (state_ff != spe_pkg::S_SCAN);

   // Datapath, memory controls and the output register.
   always_comb begin
      edge_count_in = edge_count_ff;
      reached_in    = reached_ff;
      settled_in    = settled_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      end_raw_in    = end_raw_ff;
      cnt_in        = cnt_ff;
      pend_vld_in   = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      ei_in         = ei_ff;
      dst_in        = dst_ff;
      nd_in         = nd_ff;
      cur_in        = cur_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      tot_in        = tot_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      edge_we    = 1'b0;
      edge_waddr = edge_count_ff[EA-1:0];
      edge_wdata = {NB'(req_payload.edge_from), NB'(req_payload.edge_to),
                    WEIGHT_BITS'(req_payload.edge_weight)};
      node_we    = 1'b0;
      node_waddr = dst_ff;
      node_wdata = {nd_ff, best_ff};
      node_raddr = end_ff;
      path_we    = 1'b0;
      path_waddr = NB'(len_ff);
      path_wdata = cur_ff;

      unique case (state_ff)
         spe_pkg::S_IDLE: begin
            if (req_fire) begin
               if (!req_payload.mode) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.path_node      = '0;
                  rsp_in.total_distance = '0;
                  rsp_in.last           = 1'b1;
                  if (edge_ok) begin
                     edge_we       = 1'b1;
                     edge_count_in = edge_count_ff + EC'(1);
                     rsp_in.status = spe_pkg::STAT_ACCEPTED;
                  end else begin
                     rsp_in.status = spe_pkg::STAT_FULL;
                  end
               end else begin
                  start_in   = NB'(req_payload.path_start);
                  end_in     = NB'(req_payload.path_end);
                  end_raw_in = req_payload.path_end;
               end
            end
         end
         spe_pkg::S_INIT: begin
            node_we              = 1'b1;
            node_waddr           = start_ff;
            node_wdata           = {DB'(0), start_ff};
            reached_in           = '0;
            reached_in[start_ff] = 1'b1;
            settled_in           = '0;
         end
         spe_pkg::S_SCAN: begin
            found_in     = scan_found;
            best_in      = scan_best;
            best_dist_in = scan_bdist;
            if (!scan_end) begin
               node_raddr  = cnt_ff[NB-1:0];
               pend_vld_in = 1'b1;
               pend_idx_in = cnt_ff[NB-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else if (scan_found) begin
               settled_in[scan_best] = 1'b1;
               ei_in                 = '0;
            end
         end
         spe_pkg::S_RELAX_RD: begin
         end
         spe_pkg::S_RELAX_EDGE: begin
            node_raddr = e_dst;
            dst_in     = e_dst;
            nd_in      = (relax_sum > SW'(spe_pkg::DIST_MAX)) ? spe_pkg::DIST_MAX
                                                              : DB'(relax_sum);
            if (!relax_hit) begin
               ei_in = ei_next;
            end
         end
         spe_pkg::S_RELAX_NODE: begin
            ei_in = ei_next;
            if (!reached_ff[dst_ff] || (nd_ff < rd_dist)) begin
               node_we            = 1'b1;
               reached_in[dst_ff] = 1'b1;
            end
         end
         spe_pkg::S_TDIST: begin
            tot_in = rd_dist;
            cur_in = end_ff;
            len_in = '0;
         end
         spe_pkg::S_TRACE_RD: begin
            path_we    = 1'b1;
            len_in     = len_ff + CW'(1);
            node_raddr = cur_ff;
            k_in       = '0;
         end
         spe_pkg::S_TRACE_WAIT: begin
            cur_in = rd_pred;
         end
         spe_pkg::S_EMIT_RD: begin
         end
         spe_pkg::S_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = spe_pkg::STAT_PATH;
               rsp_in.path_node      = 4'(path_rdata);
               rsp_in.total_distance = tot_ff;
               rsp_in.last           = emit_last;
               k_in                  = k_ff + CW'(1);
            end
         end
         spe_pkg::S_NOROUTE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = spe_pkg::STAT_NOROUTE;
               rsp_in.path_node      = end_raw_ff;
               rsp_in.total_distance = '0;
               rsp_in.last           = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (restart_scan) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spe_pkg::S_IDLE;
         edge_count_ff <= '0;
         reached_ff    <= '0;
         settled_ff    <= '0;
         pend_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         reached_ff    <= reached_in;
         settled_ff    <= settled_in;
         pend_vld_ff   <= pend_vld_in;
         found_ff      <= found_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      end_ff       <= end_in;
      end_raw_ff   <= end_raw_in;
      pend_idx_ff  <= pend_idx_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      ei_ff        <= ei_in;
      dst_ff       <= dst_in;
      nd_ff        <= nd_in;
      cur_ff       <= cur_in;
      len_ff       <= len_in;
      k_ff         <= k_in;
      tot_ff       <= tot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A settled node must always have been reached.
   `SPE_ASSERT_IMPL(settled_implies_reached, clock, reset, 1'b1, (settled_ff & ~reached_ff) == '0)
   // The node memory is written only at query start and while relaxing an edge.
   `SPE_ASSERT_IMPL(node_write_states, clock, reset, node_we, (state_ff == spe_pkg::S_INIT) || (state_ff == spe_pkg::S_RELAX_NODE))
   // An edge transfer yields its result in the following cycle.
   `SPE_ASSERT_NEXT(edge_result_next, clock, reset, req_fire && !req_payload.mode, rsp_valid_ff && rsp_ff.last)

endmodule

### tb/tb.sv
// Self-checking testbench for the shortest path engine: edge adds and Dijkstra queries.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 16;
   localparam int EDGES = 64;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   spe_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   spe_pkg::rsp_type rsp_payload;

   shortest_path_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   // Our own copy of the graph, kept in step with every accepted transfer.
   logic [3:0]  graph_src [EDGES];
   logic [3:0]  graph_dst [EDGES];
   logic [15:0] graph_len [EDGES];
   int          graph_edges = 0;

   spe_pkg::rsp_type pending_results[$];
   int               fail_count = 0;

   // Sender burst state: a run of back-to-back items, then an idle gap.
   int burst_left = 0;
   int gap_len = 0;

   function automatic spe_pkg::rsp_type make_rsp(spe_pkg::status_type st, logic [3:0] node,
                                                 logic [19:0] dist_val, logic lst);
      spe_pkg::rsp_type r;
      r.status = st;
      r.path_node = node;
      r.total_distance = dist_val;
      r.last = lst;
      return r;
   endfunction

   // Appends one expected result behind those already waiting.
   function automatic void queue_result(spe_pkg::rsp_type r);
      pending_results = {pending_results, r};
   endfunction

   // Works out the results of one query by Dijkstra over the stored edges.
   function automatic void route_query(logic [3:0] s, logic [3:0] e);
      bit          reached [NODES];
      logic [19:0] node_dist [NODES];
      logic [3:0]  pred [NODES];
      logic [15:0] settled;
      logic [3:0]  trail [$];
      logic [3:0]  cur;
      logic [20:0] nd;
      int          best;
      bit          found;
      for (int n = 0; n < NODES; n++) begin
         reached[n] = 0;
         node_dist[n] = '0;
         pred[n] = '0;
      end
      settled = '0;
      reached[s] = 1;
      pred[s] = s;
      for (int round = 0; round < NODES; round++) begin
         found = 0;
         best = 0;
         for (int n = 0; n < NODES; n++) begin
            if (reached[n] && !settled[n] && (!found || node_dist[n] < node_dist[best])) begin
               best = n;
               found = 1;
            end
         end
         if (!found) break;
         settled[best] = 1'b1;
         // Edges are relaxed in store order; only a strictly shorter distance wins.
         for (int i = 0; i < graph_edges; i++) begin
            if (graph_src[i] == best && !settled[graph_dst[i]]) begin
               nd = node_dist[best] + graph_len[i];
               if (nd > spe_pkg::DIST_MAX) nd = spe_pkg::DIST_MAX;
               if (!reached[graph_dst[i]] || nd[19:0] < node_dist[graph_dst[i]]) begin
                  reached[graph_dst[i]] = 1;
                  node_dist[graph_dst[i]] = nd[19:0];
                  pred[graph_dst[i]] = best[3:0];
               end
            end
         end
      end
      if (!reached[e]) begin
         queue_result(make_rsp(spe_pkg::STAT_NOROUTE, e, '0, 1'b1));
         return;
      end
      cur = e;
      trail.push_front(cur);
      while (cur != s && trail.size() < NODES) begin
         cur = pred[cur];
         trail.push_front(cur);
      end
      foreach (trail[k])
         queue_result(make_rsp(spe_pkg::STAT_PATH, trail[k], node_dist[e],
                               k == trail.size() - 1));
   endfunction

   function automatic void predict_results(spe_pkg::req_type r);
      if (r.mode) begin
         route_query(r.path_start, r.path_end);
      end else if (graph_edges >= EDGES) begin
         queue_result(make_rsp(spe_pkg::STAT_FULL, '0, '0, 1'b1));
      end else begin
         graph_src[graph_edges] = r.edge_from;
         graph_dst[graph_edges] = r.edge_to;
         graph_len[graph_edges] = r.edge_weight;
         graph_edges++;
         queue_result(make_rsp(spe_pkg::STAT_ACCEPTED, '0, '0, 1'b1));
      end
   endfunction

   // Offers one item and returns at the edge where the transfer takes place.
   task automatic send_item(spe_pkg::req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= r;
      // Inputs only change at the rising edge, so the falling edge shows what the
      // next rising edge will see.
      forever begin
         @(negedge clock);
         if (req_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      predict_results(r);
   endtask

   task automatic add_edge(logic [3:0] a, logic [3:0] b, logic [15:0] w);
      spe_pkg::req_type r;
      r = '0;
      r.edge_from = a;
      r.edge_to = b;
      r.edge_weight = w;
      r.path_start = 4'($urandom);
      r.path_end = 4'($urandom);
      send_item(r);
   endtask

   task automatic ask_route(logic [3:0] s, logic [3:0] e);
      spe_pkg::req_type r;
      r = '0;
      r.mode = 1'b1;
      r.edge_from = 4'($urandom);
      r.edge_to = 4'($urandom);
      r.edge_weight = 16'($urandom);
      r.path_start = s;
      r.path_end = e;
      send_item(r);
   endtask

   // Zero and full-scale weights, duplicates, a self-loop and both node extremes.
   task automatic test_directed_edges();
      add_edge(4'd0, 4'd1, 16'd0);
      add_edge(4'd1, 4'd2, 16'hFFFF);
      add_edge(4'd0, 4'd2, 16'hFFFF);
      add_edge(4'd0, 4'd3, 16'd5);
      add_edge(4'd0, 4'd4, 16'd5);
      add_edge(4'd3, 4'd15, 16'd10);
      add_edge(4'd4, 4'd15, 16'd10);
      add_edge(4'd15, 4'd15, 16'd1);
      add_edge(4'd2, 4'd7, 16'd3);
      add_edge(4'd2, 4'd7, 16'd3);
   endtask

   // Start equals end, a tie between two routes, a dead end and an unreached node.
   task automatic test_directed_queries();
      ask_route(4'd0, 4'd0);
      ask_route(4'd0, 4'd15);
      ask_route(4'd0, 4'd2);
      ask_route(4'd0, 4'd7);
      ask_route(4'd15, 4'd0);
      ask_route(4'd9, 4'd9);
      ask_route(4'd5, 4'd6);
   endtask

   // Mostly edges while the store has room, then queries over the finished graph.
   task automatic test_random_graph(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < ((graph_edges < EDGES) ? 75 : 35))
            add_edge(4'($urandom), 4'($urandom),
                     ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
         else
            ask_route(4'($urandom), 4'($urandom));
      end
   endtask

   // Edges offered once the store is full must all be dropped.
   task automatic test_table_full();
      while (graph_edges < EDGES)
         add_edge(4'($urandom), 4'($urandom), 16'($urandom));
      repeat (4) add_edge(4'($urandom), 4'($urandom), 16'($urandom));
      ask_route(4'd0, 4'd15);
   endtask

   // The receiver stalls on a pattern with three phases: always ready, random, mostly stalled.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 900;
      if (stall_phase < 300)
         rsp_ready <= 1'b1;
      else if (stall_phase < 600)
         rsp_ready <= $urandom_range(0, 1);
      else
         rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   // Each transfer on the result side is checked against the oldest expectation.
   always @(negedge clock) begin
      spe_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result, status %0d", rsp_payload.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.path_node !== want.path_node) begin
               $error("path_node expected %0d got %0d", want.path_node,
                      rsp_payload.path_node);
               fail_count++;
            end
            if (rsp_payload.total_distance !== want.total_distance) begin
               $error("total_distance expected %0d got %0d", want.total_distance,
                      rsp_payload.total_distance);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_directed_queries();
      test_random_graph(440);
      test_table_full();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // A time limit far beyond the slowest correct run.
   initial begin
      #50ms;
      $display("tb: errors");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_ram.sv
rtl/shortest_path_engine.sv
tb/tb.sv
